### sv/tcw_pkg.sv
// Shared constants and codes for the text console writer.
// Used by text_console_writer_unit; no other dependencies.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int WPOS_W  = ADDR_W + 1;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int CELL_W  = 16;

    // fixed field widths of the item ports
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INCOL_W = 7;
    localparam int INROW_W = 5;
    localparam int CUR_W   = 12;
    localparam int POS_W   = 11;
    localparam int ATTR_W  = 8;
    localparam int HDR_W   = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CUR_W-1:0]  HIDDEN_CURSOR = CUR_W'((ROWS + 1) * COLUMNS);
    localparam logic [ATTR_W-1:0] FILL_ATTR     = 8'h0F;
    localparam logic [CHAR_W-1:0] BLANK         = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h0F;

    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PRINT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUT   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS    = 2'd2;

endpackage

### sv/text_console_writer_unit.sv
// Text console writer top level: control sequencer around the cell store RAM.
// Depends on tcw_pkg and tcw_ram.
//
// An 80x25 text console: each cell of the store holds a character (low byte) and an
// attribute (high byte). Items arrive on i_valid/o_stall and each gives one result beat on
// o_valid/i_stall; a finished result waits in the output register while the next item is
// taken. The cell store is a single-port-write, single-port-read RAM with a registered read.
// A print that runs past the last row scrolls, walking the store one cell a cycle. The store
// is not cleared at reset; its cells are undefined until written by print, put, clear or
// scroll. Configuration writes are always ready and must come only while the block is idle.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [CHAR_W-1:0]     i_ch,
    input  logic [INCOL_W-1:0]    i_column,
    input  logic [INROW_W-1:0]    i_row,
    // result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CUR_W-1:0]      o_cursor_position,
    output logic [POS_W-1:0]      o_text_position,
    output logic [CHAR_W-1:0]     o_cell_char,
    output logic [ATTR_W-1:0]     o_cell_attr,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // control state
    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic [HDR_W-1:0]  r_hdr, n_hdr;
    logic              r_vis, n_vis;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    // payload
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [CHAR_W-1:0]  r_ch, n_ch;
    logic [INCOL_W-1:0] r_in_col, n_in_col;
    logic [INROW_W-1:0] r_in_row, n_in_row;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic [CHAR_W-1:0]  r_cell_char, n_cell_char;
    logic [ATTR_W-1:0]  r_cell_attr, n_cell_attr;
    logic [CUR_W-1:0]   r_out_cursor, n_out_cursor;
    logic [ADDR_W-1:0]  r_out_pos, n_out_pos;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic [ATTR_W-1:0]  r_out_attr, n_out_attr;

    // cell store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              out_free;
    logic              fin;
    logic              in_range;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] hdr_base;
    logic [WPOS_W-1:0] np;
    logic [COL_W:0]    col_sum;
    logic [2:0]        tab_add;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign in_range  = (int'(r_in_col) < COLUMNS) && (int'(r_in_row) < ROWS);
    assign cell_addr = ADDR_W'(int'(r_in_row) * COLUMNS + int'(r_in_col));
    assign hdr_base  = ADDR_W'(int'(r_hdr) * COLUMNS);
    assign tab_add   = (r_pos[1:0] == 2'd0) ? 3'd4 : {1'b0, r_pos[1:0]};

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_col        = r_col;
        n_cursor     = r_cursor;
        n_attr       = r_attr;
        n_hdr        = r_hdr;
        n_vis        = r_vis;
        n_pend       = 1'b0;
        n_out_valid  = r_out_valid;
        n_func       = r_func;
        n_ch         = r_ch;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_addr       = r_addr;
        n_pend_addr  = r_pend_addr;
        n_cell_char  = r_cell_char;
        n_cell_attr  = r_cell_attr;
        n_out_cursor = r_out_cursor;
        n_out_pos    = r_out_pos;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = {FILL_ATTR, BLANK};
        ram_raddr    = ADDR_W'(int'(r_addr) + COLUMNS);
        fin          = 1'b0;
        np           = {1'b0, r_pos};
        col_sum      = {1'b0, r_col};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTR: begin
                    n_attr = i_cfg_data;
                end
                CFG_HEADER: begin
                    if (int'(i_cfg_data[HDR_W-1:0]) + 3 <= ROWS) begin
                        n_hdr = i_cfg_data[HDR_W-1:0];
                    end
                end
                CFG_VIS: begin
                    n_vis = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end

        // land the scroll copy read in the cycle after it was issued
        if (r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_pend_addr;
            ram_wdata = ram_rdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func   = i_func;
                    n_ch     = i_ch;
                    n_in_col = i_column;
                    n_in_row = i_row;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell_char = '0;
                n_cell_attr = '0;
                unique case (r_func)
                    FN_PRINT: begin
                        priority if (r_ch == CH_NL) begin
                            np    = WPOS_W'(int'(r_pos) + COLUMNS - int'(r_col));
                            n_col = '0;
                        end else if (r_ch == CH_BS) begin
                            if (r_pos != '0) begin
                                np    = {1'b0, r_pos} - WPOS_W'(1);
                                n_col = (r_col == '0) ? COL_W'(COLUMNS - 1) : r_col - COL_W'(1);
                            end
                            ram_we    = 1'b1;
                            ram_waddr = np[ADDR_W-1:0];
                            ram_wdata = {r_attr, BLANK};
                        end else if (r_ch == CH_TAB) begin
                            np      = {1'b0, r_pos} + WPOS_W'(tab_add);
                            col_sum = {1'b0, r_col} + (COL_W + 1)'(tab_add);
                            if (int'(col_sum) >= COLUMNS) begin
                                col_sum = col_sum - (COL_W + 1)'(COLUMNS);
                            end
                            n_col = col_sum[COL_W-1:0];
                        end else begin
                            np        = {1'b0, r_pos} + WPOS_W'(1);
                            n_col     = (int'(r_col) == COLUMNS - 1) ? '0 : r_col + COL_W'(1);
                            ram_we    = 1'b1;
                            ram_waddr = r_pos;
                            ram_wdata = {r_attr, r_ch};
                        end
                        if (int'(np) >= CELLS) begin
                            // past the last row: scroll, then step back one row
                            n_pos   = ADDR_W'(int'(np) - COLUMNS);
                            n_addr  = hdr_base;
                            n_state = S_SCROLL;
                        end else begin
                            n_pos    = np[ADDR_W-1:0];
                            n_cursor = r_vis ? CUR_W'(np) : HIDDEN_CURSOR;
                            fin      = 1'b1;
                        end
                    end
                    FN_PUT: begin
                        if (in_range && r_ch != CH_NL && r_ch != CH_BS && r_ch != CH_TAB) begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr;
                            ram_wdata = {r_attr, r_ch};
                        end
                        fin = 1'b1;
                    end
                    FN_CLEAR: begin
                        n_addr  = hdr_base;
                        n_state = S_CLEAR;
                    end
                    FN_READ: begin
                        ram_raddr = cell_addr;
                        n_state   = S_READ;
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                n_cell_char = in_range ? ram_rdata[CHAR_W-1:0] : '0;
                n_cell_attr = in_range ? ram_rdata[CELL_W-1:CHAR_W] : '0;
                fin         = 1'b1;
            end
            S_SCROLL: begin
                // read the cell one row below, write it back next cycle
                n_pend      = 1'b1;
                n_pend_addr = r_addr;
                if (r_addr == LAST_COPY) begin
                    n_addr  = FILL_START;
                    n_state = S_FILL;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_FILL: begin
                if (!r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = {FILL_ATTR, 8'h00};
                    if (r_addr == LAST_CELL) begin
                        n_cursor = r_vis ? CUR_W'(r_pos) : HIDDEN_CURSOR;
                        fin      = 1'b1;
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = {FILL_ATTR, BLANK};
                if (r_addr == LAST_CELL) begin
                    n_pos = hdr_base;
                    n_col = '0;
                    fin   = 1'b1;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = r_cursor;
                    n_out_pos    = r_pos;
                    n_out_char   = r_cell_char;
                    n_out_attr   = r_cell_attr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // deliver the result beat now if the output register is free, else hold it
        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_cursor = n_cursor;
                n_out_pos    = n_pos;
                n_out_char   = n_cell_char;
                n_out_attr   = n_cell_attr;
                n_state      = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_col       <= '0;
            r_cursor    <= '0;
            r_attr      <= ATTR_RESET;
            r_hdr       <= '0;
            r_vis       <= 1'b1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_cursor    <= n_cursor;
            r_attr      <= n_attr;
            r_hdr       <= n_hdr;
            r_vis       <= n_vis;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_ch         <= n_ch;
        r_in_col     <= n_in_col;
        r_in_row     <= n_in_row;
        r_addr       <= n_addr;
        r_pend_addr  <= n_pend_addr;
        r_cell_char  <= n_cell_char;
        r_cell_attr  <= n_cell_attr;
        r_out_cursor <= n_out_cursor;
        r_out_pos    <= n_out_pos;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_cursor_position = r_out_cursor;
    assign o_text_position   = POS_W'(r_out_pos);
    assign o_cell_char       = r_out_char;
    assign o_cell_attr       = r_out_attr;
    assign o_cfg_ready       = 1'b1;

endmodule

### sv/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### dv/text_console_writer_unit_tb.sv
// Self-checking testbench for text_console_writer_unit: random and directed console
// operations against an in-bench prediction of the cell store. Depends on tcw_pkg.
`timescale 1ns / 100ps

module text_console_writer_unit_tb;
    import tcw_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAR_W-1:0]  ch;
        logic [INCOL_W-1:0] column;
        logic [INROW_W-1:0] row;
    } console_op_t;

    typedef struct packed {
        logic [CUR_W-1:0]  cursor;
        logic [POS_W-1:0]  tpos;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } console_result_t;

    // Mirror of the console: cell store, write position, cursor and settings.
    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int unsigned       wpos;
        logic [CUR_W-1:0]  cursor_reg;
        logic [ATTR_W-1:0] text_attr;
        int unsigned       header;
        bit                cursor_on;
        console_result_t   expected_q[$];
        int                errors;

        function new();
            wpos       = 0;
            cursor_reg = '0;
            text_attr  = ATTR_RESET;
            header     = 0;
            cursor_on  = 1'b1;
            errors     = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ATTR:   text_attr = data;
                CFG_HEADER: begin
                    // a header that leaves fewer than three rows is dropped
                    if (int'(data[HDR_W-1:0]) + 3 <= ROWS)
                        header = data[HDR_W-1:0];
                end
                CFG_VIS:    cursor_on = data[0];
                default: ;
            endcase
        endfunction

        function void note_item(console_op_t op);
            console_result_t r;
            int unsigned     m;
            int unsigned     p;
            bit              in_range;
            r = '0;
            in_range = (op.column < COLUMNS) && (op.row < ROWS);
            case (op.func)
                FN_PRINT: begin
                    if (op.ch == CH_NL) begin
                        wpos += COLUMNS - wpos % COLUMNS;
                    end else if (op.ch == CH_BS) begin
                        if (wpos > 0) wpos--;
                        cells[wpos] = {text_attr, BLANK};
                    end else if (op.ch == CH_TAB) begin
                        // odd tab rule: a multiple of 4 steps 4, otherwise steps pos mod 4
                        m = wpos % 4;
                        wpos += (m == 0) ? 4 : m;
                    end else begin
                        cells[wpos] = {text_attr, op.ch};
                        wpos++;
                    end
                    if (wpos >= CELLS) begin
                        for (p = header * COLUMNS; p < (ROWS - 1) * COLUMNS; p++)
                            cells[p] = cells[p + COLUMNS];
                        for (p = (ROWS - 1) * COLUMNS; p < CELLS; p++)
                            cells[p] = {FILL_ATTR, 8'h00};
                        wpos -= COLUMNS;
                    end
                    cursor_reg = cursor_on ? CUR_W'(wpos) : HIDDEN_CURSOR;
                end
                FN_PUT: begin
                    if (in_range && op.ch != CH_NL && op.ch != CH_BS && op.ch != CH_TAB)
                        cells[op.row * COLUMNS + op.column] = {text_attr, op.ch};
                end
                FN_CLEAR: begin
                    for (p = header * COLUMNS; p < CELLS; p++)
                        cells[p] = {FILL_ATTR, BLANK};
                    wpos = header * COLUMNS;
                end
                FN_READ: begin
                    if (in_range)
                        {r.cell_attr, r.cell_char} = cells[op.row * COLUMNS + op.column];
                end
            endcase
            r.cursor = cursor_reg;
            r.tpos   = POS_W'(wpos);
            expected_q.push_back(r);
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat with nothing expected: cur=%0d pos=%0d ch=%h at=%h",
                             $realtime, got.cursor, got.tpos, got.cell_char, got.cell_attr);
                return;
            end
            want = expected_q.pop_front();
            if (got.cursor !== want.cursor || got.tpos !== want.tpos ||
                got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp cur=%0d pos=%0d ch=%h at=%h, got cur=%0d pos=%0d ch=%h at=%h",
                             $realtime, want.cursor, want.tpos, want.cell_char, want.cell_attr,
                             got.cursor, got.tpos, got.cell_char, got.cell_attr);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [FUNC_W-1:0]     i_func      = '0;
    logic [CHAR_W-1:0]     i_ch        = '0;
    logic [INCOL_W-1:0]    i_column    = '0;
    logic [INROW_W-1:0]    i_row       = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [CUR_W-1:0]      o_cursor_position;
    logic [POS_W-1:0]      o_text_position;
    logic [CHAR_W-1:0]     o_cell_char;
    logic [ATTR_W-1:0]     o_cell_attr;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    console_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    text_console_writer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_ch              (i_ch),
        .i_column          (i_column),
        .i_row             (i_row),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_cursor_position (o_cursor_position),
        .o_text_position   (o_text_position),
        .o_cell_char       (o_cell_char),
        .o_cell_attr       (o_cell_attr),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Result side: long hold-off on request, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(console_result_t'({o_cursor_position, o_text_position,
                                               o_cell_char, o_cell_attr}));
    end

    function automatic console_op_t console_op(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c,
                                               logic [INCOL_W-1:0] col, logic [INROW_W-1:0] row);
        return '{func: f, ch: c, column: col, row: row};
    endfunction

    // Called in the step of a rising edge; returns in the step of the accepting edge.
    task automatic send_item(console_op_t op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_func   <= op.func;
        i_ch     <= op.ch;
        i_column <= op.column;
        i_row    <= op.row;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [7:0] attr, logic [7:0] hdr, logic [7:0] vis);
        cfg_write(CFG_ATTR, attr);
        cfg_write(CFG_HEADER, hdr);
        cfg_write(CFG_VIS, vis);
    endtask

    function automatic logic [INCOL_W-1:0] pick_column();
        return ($urandom_range(99) < 85) ? INCOL_W'($urandom_range(COLUMNS - 1))
                                         : INCOL_W'($urandom_range(127));
    endfunction

    function automatic logic [INROW_W-1:0] pick_row();
        return ($urandom_range(99) < 85) ? INROW_W'($urandom_range(ROWS - 1))
                                         : INROW_W'($urandom_range(31));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(int ctrl_pct);
        int r;
        r = $urandom_range(99);
        if (r < ctrl_pct / 2)         return CH_NL;
        if (r < (ctrl_pct * 3) / 4)   return CH_BS;
        if (r < ctrl_pct)             return CH_TAB;
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic console_op_t random_op();
        int r;
        r = $urandom_range(99);
        if (r < 45) return console_op(FN_PRINT, pick_char(26), pick_column(), pick_row());
        if (r < 68) return console_op(FN_PUT, pick_char(10), pick_column(), pick_row());
        if (r < 97) return console_op(FN_READ, pick_char(0), pick_column(), pick_row());
        return console_op(FN_CLEAR, pick_char(0), pick_column(), pick_row());
    endfunction

    // Mostly lines of text and runs of newlines, so the position reaches the bottom and scrolls.
    task automatic run_random(int count);
        int sent;
        int k;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                k = $urandom_range(1, 100);
                repeat (k)
                    send_item(console_op(FN_PRINT, ($urandom_range(99) < 80) ?
                                         CHAR_W'($urandom_range(32, 126)) :
                                         CHAR_W'($urandom_range(255)),
                                         pick_column(), pick_row()));
                send_item(console_op(FN_PRINT, CH_NL, pick_column(), pick_row()));
                sent += k + 1;
            end else if (pick < 55) begin
                k = $urandom_range(3, 30);
                repeat (k) send_item(console_op(FN_PRINT, CH_NL, pick_column(), pick_row()));
                sent += k;
            end else begin
                send_item(random_op());
                sent++;
            end
        end
    endtask

    initial begin
        #(100_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sb = new();
        send_idle_pct = 34;
        recv_idle_pct = 71;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clear first: every cell is written before any read
        send_item(console_op(FN_CLEAR, 8'h00, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, 8'h41, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, 8'h00, 7'd127, 5'd31));
        send_item(console_op(FN_PRINT, 8'hFF, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, CH_TAB, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, CH_TAB, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, CH_TAB, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, CH_BS, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, CH_NL, 7'd0, 5'd0));
        send_item(console_op(FN_PUT, 8'hFF, 7'd79, 5'd24));
        send_item(console_op(FN_PUT, 8'h7E, 7'd0, 5'd0));
        send_item(console_op(FN_PUT, CH_NL, 7'd5, 5'd5));
        send_item(console_op(FN_PUT, CH_BS, 7'd6, 5'd5));
        send_item(console_op(FN_PUT, CH_TAB, 7'd7, 5'd5));
        send_item(console_op(FN_PUT, 8'h55, 7'd80, 5'd0));
        send_item(console_op(FN_PUT, 8'h55, 7'd127, 5'd31));
        send_item(console_op(FN_PUT, 8'h55, 7'd3, 5'd25));
        send_item(console_op(FN_READ, 8'h00, 7'd79, 5'd24));
        send_item(console_op(FN_READ, 8'hFF, 7'd0, 5'd0));
        send_item(console_op(FN_READ, 8'h00, 7'd6, 5'd5));
        send_item(console_op(FN_READ, 8'h00, 7'd80, 5'd3));
        send_item(console_op(FN_READ, 8'h00, 7'd3, 5'd25));
        send_item(console_op(FN_READ, 8'h00, 7'd127, 5'd31));
        send_item(console_op(FN_CLEAR, 8'h00, 7'd0, 5'd0));
        send_item(console_op(FN_PRINT, CH_BS, 7'd0, 5'd0));
        send_item(console_op(FN_READ, 8'h00, 7'd0, 5'd0));
        drain_results();

        apply_settings(8'h00, 8'd0, 8'h01);
        run_random(200);
        drain_results();

        apply_settings(8'hFF, 8'd22, 8'h00);
        run_random(200);

        // hold the result side off so the block backs up and stalls its input
        hold_request = 400;
        repeat (40)
            send_item(console_op(($urandom_range(1) != 0) ? FN_PUT : FN_READ,
                                 CHAR_W'($urandom_range(255)), pick_column(), pick_row()));
        drain_results();

        send_idle_pct = 71;
        recv_idle_pct = 34;
        cfg_write(CFG_HEADER, 8'd23);
        cfg_write(CFG_HEADER, 8'hFF);
        apply_settings(8'h5A, 8'd37, 8'h01);
        run_random(200);
        drain_results();

        apply_settings(8'hA5, 8'd0, 8'hFE);
        run_random(200);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(8'h0F, 8'd12, 8'h01);
        run_random(200);
        drain_results();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer_unit.sv
dv/text_console_writer_unit_tb.sv
